/* hdl/ufr_pkg.sv */
// shared types and constants for the serial frame receiver
package ufr_pkg;

  localparam logic [7:0]  HEADER_BYTE   = 8'hFF;
  localparam logic [7:0]  ESCAPE_BYTE   = 8'h55;
  localparam logic [16:0] PAYLOAD_START = 17'd4;
  localparam logic [16:0] POS_HEADER2   = 17'd1;
  localparam logic [16:0] POS_LEN_HIGH  = 17'd2;
  localparam logic [16:0] POS_LEN_LOW   = 17'd3;

  typedef enum logic {
    OP_BYTE    = 1'b0,
    OP_RELEASE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_STORED   = 2'd0,
    ST_COMPLETE = 2'd1,
    ST_ABANDON  = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [16:0] position;
    status_t     status;
  } result_t;

endpackage

/* hdl/uart_frame_receiver.sv */
// serial frame receiver: header search, length capture, escape removal
// an accepted byte's result beat is registered in the output register, or in the skid entry while the output stalls
// throughput: one item per cycle unless item_stall; the per-byte compares and the
//   17-bit count increment sit between the input handshake and the output register
// a two-entry output stage (output register plus skid) absorbs one stalled beat
// reset (rst, synchronous): hunting for a header, no frame pending, outputs empty
module uart_frame_receiver
  import ufr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        opcode,
  input  logic [7:0]  rx_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  data_byte,
  output logic [16:0] position,
  output logic [1:0]  status
);

  logic        in_frame, in_frame_next;
  logic [16:0] byte_count, byte_count_next;
  logic [7:0]  length_high, length_high_next;
  logic [15:0] frame_length, frame_length_next;
  logic [7:0]  previous_byte, previous_byte_next;
  logic        frame_pending, frame_pending_next;

  logic        accept;
  logic        res_valid;
  result_t     res;
  logic [16:0] frame_end;

  logic        out_valid;
  result_t     out_res;
  logic        skid_valid;
  result_t     skid_res;
  logic        out_free;

  assign item_stall = skid_valid;
  assign accept     = item_valid && !item_stall;
  assign frame_end  = {1'b0, frame_length_next} + PAYLOAD_START;

  always_comb begin
    in_frame_next      = in_frame;
    byte_count_next    = byte_count;
    length_high_next   = length_high;
    frame_length_next  = frame_length;
    previous_byte_next = previous_byte;
    frame_pending_next = frame_pending;
    res_valid          = 1'b0;
    res.data_byte      = rx_byte;
    res.position       = byte_count;
    res.status         = ST_STORED;
    priority if (opcode == OP_RELEASE) begin
      frame_pending_next = 1'b0;
    end else if (frame_pending) begin
      // byte dropped while the consumer holds the frame
    end else if (!in_frame) begin
      if (rx_byte == HEADER_BYTE) begin
        in_frame_next      = 1'b1;
        byte_count_next    = POS_HEADER2;
        previous_byte_next = rx_byte;
        res_valid          = 1'b1;
        res.position       = '0;
      end
    end else if (byte_count == POS_HEADER2 && rx_byte != HEADER_BYTE) begin
      in_frame_next   = 1'b0;
      byte_count_next = '0;
      res_valid       = 1'b1;
      res.status      = ST_ABANDON;
    end else if (byte_count >= PAYLOAD_START && rx_byte == ESCAPE_BYTE &&
                 previous_byte == HEADER_BYTE) begin
      // escape after a stored 0xff, dropped
    end else begin
      if (byte_count == POS_LEN_HIGH) begin
        length_high_next = rx_byte;
      end else if (byte_count == POS_LEN_LOW) begin
        frame_length_next = {length_high, rx_byte};
      end
      previous_byte_next = rx_byte;
      byte_count_next    = byte_count + 17'd1;
      res_valid          = 1'b1;
      if (byte_count_next >= PAYLOAD_START && byte_count_next == frame_end) begin
        frame_pending_next = 1'b1;
        in_frame_next      = 1'b0;
        res.status         = ST_COMPLETE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      byte_count    <= '0;
      length_high   <= '0;
      frame_length  <= '0;
      previous_byte <= '0;
      frame_pending <= 1'b0;
    end else if (accept) begin
      in_frame      <= in_frame_next;
      byte_count    <= byte_count_next;
      length_high   <= length_high_next;
      frame_length  <= frame_length_next;
      previous_byte <= previous_byte_next;
      frame_pending <= frame_pending_next;
    end
  end

  // output register with a skid entry behind it
  assign out_free = !out_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept && res_valid;
      end
    end else if (accept && res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (accept && res_valid) begin
        out_res <= res;
      end
    end else if (accept && res_valid) begin
      skid_res <= res;
    end
  end

  assign result_valid = out_valid;
  assign data_byte    = out_res.data_byte;
  assign position     = out_res.position;
  assign status       = out_res.status;

endmodule

/* hdl/uart_frame_receiver_checker.sv */
// port-level checks for the serial frame receiver, bound to the top level
module uart_frame_receiver_checker
  import ufr_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_stall,
  input logic [7:0]  data_byte,
  input logic [16:0] position,
  input logic [1:0]  status
);

  // status code three is never produced
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (status == ST_STORED || status == ST_COMPLETE ||
                      status == ST_ABANDON))
    else $error("undefined status code on result beat");

  // abandon only happens on the second header byte, which is not 0xff
  a_abandon_pos: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status == ST_ABANDON) |->
      (position == POS_HEADER2 && data_byte != HEADER_BYTE))
    else $error("abandon beat with wrong position or byte");

  // a frame always starts on a header byte
  a_start_header: assert property (@(posedge clk) disable iff (rst)
    (result_valid && position == '0) |->
      (data_byte == HEADER_BYTE && status == ST_STORED))
    else $error("position zero beat is not a header byte");

  // a stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=>
      (result_valid && $stable(data_byte) && $stable(position) && $stable(status)))
    else $error("stalled result beat changed");

endmodule

bind uart_frame_receiver uart_frame_receiver_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .data_byte    (data_byte),
  .position     (position),
  .status       (status)
);
